// ===== rtl/true_range_window_average_macros.svh =====
// ----------------------------------------------------------------------------
// true_range_window_average_macros.svh
// Assertion macros used by the block's datapath, trwa_dp.
// ----------------------------------------------------------------------------
`ifndef TRUE_RANGE_WINDOW_AVERAGE_MACROS_SVH
`define TRUE_RANGE_WINDOW_AVERAGE_MACROS_SVH

// cond must hold at every clock edge outside reset
`define TRWA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define TRWA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/trwa_pkg.sv =====
// ----------------------------------------------------------------------------
// trwa_pkg
// Types and constants shared by the true range window average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trwa_pkg;

    localparam int PERIOD_W = 7;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    // register index taken from paddr[2]
    localparam logic REG_ATR_PERIOD = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_RANGE,
        S_UPDATE,
        S_CHECK,
        S_DIVIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;    // latch the input bar
        logic calc;       // differences, ring read, series restart
        logic range;      // pick the true range
        logic update;     // ring write, running sum, window counters
        logic check;      // sample window-full flag
        logic div_start;  // launch sum / period
        logic out_load;   // move result to output register
    } t_cmd;

    typedef struct packed {
        logic win_full;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/true_range_window_average.sv =====
// ----------------------------------------------------------------------------
// true_range_window_average
// Average true range of price bars over a sliding window of atr_period bars.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+--------------------------------
//   s_axis   | in  | s_axis_tvalid/tready       | tdata: high, low, close; tuser: start
//   m_axis   | out | m_axis_tvalid/tready       | tdata: atr_value; tuser: atr_valid
//   apb      | in  | psel/penable/pwrite/pready | 0x0: atr_period
//
// One bar at a time; a bar whose window is full goes through the bit-serial
// divide of the running sum by the period before its result is loaded; a bar
// without a full window skips the divide.
// The result register lets the next bar enter while a result waits; a bar
// that finishes before that result is taken holds until the register frees.
// Reset clears the series and the window; period resets to 14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module true_range_window_average #(
    parameter int MAX_PERIOD = 64,
    parameter int PRICE_BITS = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // high_price, low_price, close_price
    input  wire logic [((3*PRICE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // series_start
    input  wire logic                                   s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // atr_value
    output logic [((PRICE_BITS+7)/8)*8-1:0]             m_axis_tdata,
    // atr_valid
    output logic                                        m_axis_tuser,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [trwa_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire logic [trwa_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [trwa_pkg::CFG_DATA_W-1:0]             prdata,
    output logic                                        pready
);
    import trwa_pkg::*;

    localparam int OUT_W = ((PRICE_BITS + 7) / 8) * 8;

    logic [PERIOD_W-1:0]   r_atr_period;
    logic                  cfg_wr;
    t_cmd                  cmd;
    t_sts                  sts;
    logic [PRICE_BITS-1:0] out_value;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ATR_PERIOD);
    assign prdata = (paddr[2] == REG_ATR_PERIOD) ? CFG_DATA_W'(r_atr_period) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atr_period <= PERIOD_RESET;
        end else if (cfg_wr) begin
            r_atr_period <= pwdata[PERIOD_W-1:0];
        end
    end

    trwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    trwa_dp #(
        .MAX_PERIOD (MAX_PERIOD),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_period    (r_atr_period),
        .i_cfg_clear (cfg_wr),
        .i_start     (s_axis_tuser),
        .i_high      (s_axis_tdata[PRICE_BITS-1:0]),
        .i_low       (s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS]),
        .i_close     (s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_flag  (m_axis_tuser),
        .o_out_value (out_value)
    );

    assign m_axis_tdata = OUT_W'(out_value);

endmodule

`default_nettype wire

// ===== rtl/trwa_div.sv =====
// ----------------------------------------------------------------------------
// trwa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trwa_div #(
    parameter int SUM_W = 38
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [SUM_W-1:0]              i_dividend,
    input  wire logic [trwa_pkg::PERIOD_W-1:0] i_divisor,
    output logic                               o_busy,
    output logic [SUM_W-1:0]                   o_quotient
);
    import trwa_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_quo;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_dvs;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                ge;
    logic [PERIOD_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(SUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/trwa_ctrl.sv =====
// ----------------------------------------------------------------------------
// trwa_ctrl
// Sequencer: walks one bar through the datapath steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trwa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire trwa_pkg::t_sts i_sts,
    output trwa_pkg::t_cmd     o_cmd
);
    import trwa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_RANGE;
            end
            S_RANGE: begin
                o_cmd.range = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.win_full) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIVIDE: begin
                if (!i_sts.div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/trwa_dp.sv =====
// ----------------------------------------------------------------------------
// trwa_dp
// Datapath: true range, range ring, running sum, divider, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "true_range_window_average_macros.svh"

module trwa_dp #(
    parameter int MAX_PERIOD = 64,
    parameter int PRICE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire trwa_pkg::t_cmd                i_cmd,
    output trwa_pkg::t_sts                     o_sts,
    input  wire logic [trwa_pkg::PERIOD_W-1:0] i_period,
    input  wire logic                          i_cfg_clear,
    input  wire logic                          i_start,
    input  wire logic [PRICE_BITS-1:0]         i_high,
    input  wire logic [PRICE_BITS-1:0]         i_low,
    input  wire logic [PRICE_BITS-1:0]         i_close,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_out_flag,
    output logic [PRICE_BITS-1:0]              o_out_value
);
    import trwa_pkg::*;

    localparam int AW    = $clog2(MAX_PERIOD);
    localparam int SUM_W = PRICE_BITS + AW;
    localparam int CW    = ((AW > PERIOD_W) ? AW : PERIOD_W) + 1;

    // input bar
    logic                  r_start;
    logic [PRICE_BITS-1:0] r_high;
    logic [PRICE_BITS-1:0] r_low;
    logic [PRICE_BITS-1:0] r_close;

    // series state
    logic [PRICE_BITS-1:0] r_prev_close;
    logic                  r_have_prev;
    logic [AW-1:0]         r_pos;
    logic [PERIOD_W-1:0]   r_held;
    logic [SUM_W-1:0]      r_sum;

    // per-item intermediates
    logic [PRICE_BITS-1:0] r_hl;
    logic [PRICE_BITS-1:0] r_hc;
    logic [PRICE_BITS-1:0] r_lc;
    logic [PRICE_BITS-1:0] r_tr;
    logic [AW-1:0]         r_wr_pos;
    logic                  r_do_upd;
    logic                  r_win_full_q;

    logic [PRICE_BITS-1:0] r_ring [MAX_PERIOD];
    logic [PRICE_BITS-1:0] r_ring_q;

    logic                  r_out_valid;
    logic                  r_out_flag;
    logic [PRICE_BITS-1:0] r_out_value;

    logic [PERIOD_W-1:0]   period_eff;
    logic [AW-1:0]         pos_eff;
    logic [CW-1:0]         pos_inc;
    logic [AW-1:0]         n_pos;
    logic                  full_now;
    logic                  win_full;
    logic [PRICE_BITS-1:0] tr_max;
    logic [SUM_W-1:0]      n_sum;
    logic                  div_busy;
    logic [SUM_W-1:0]      quotient;
    logic                  out_free;

    always_comb begin
        period_eff = (32'(i_period) > 32'(MAX_PERIOD)) ? PERIOD_W'(MAX_PERIOD) : i_period;
        // wrap a stale position after a shorter period, and restart on a new series
        pos_eff    = (r_start || (CW'(r_pos) >= CW'(period_eff))) ? '0 : r_pos;
        pos_inc    = CW'(r_wr_pos) + CW'(1);
        n_pos      = (pos_inc >= CW'(period_eff)) ? '0 : pos_inc[AW-1:0];
        full_now   = (r_held >= period_eff);
        win_full   = (period_eff != '0) && full_now;
        tr_max     = r_hl;
        if (r_hc > tr_max) begin
            tr_max = r_hc;
        end
        if (r_lc > tr_max) begin
            tr_max = r_lc;
        end
        n_sum      = r_sum + SUM_W'(r_tr) - (full_now ? SUM_W'(r_ring_q) : '0);
        out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_start <= i_start;
            r_high  <= i_high;
            r_low   <= i_low;
            r_close <= i_close;
        end
        if (i_cmd.calc) begin
            r_hl     <= (r_high > r_low) ? (r_high - r_low) : '0;
            r_hc     <= (r_high >= r_prev_close) ? (r_high - r_prev_close)
                                                 : (r_prev_close - r_high);
            r_lc     <= (r_low >= r_prev_close) ? (r_low - r_prev_close)
                                                : (r_prev_close - r_low);
            r_wr_pos <= pos_eff;
            r_ring_q <= r_ring[pos_eff];
        end
        if (i_cmd.range) begin
            r_tr <= tr_max;
        end
        if (i_cmd.update && r_do_upd) begin
            r_ring[r_wr_pos] <= r_tr;
        end
        if (i_cmd.check) begin
            r_win_full_q <= win_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_close <= '0;
            r_have_prev  <= 1'b0;
            r_pos        <= '0;
            r_held       <= '0;
            r_sum        <= '0;
            r_do_upd     <= 1'b0;
        end else begin
            if (i_cmd.calc) begin
                r_do_upd <= !r_start && r_have_prev && (period_eff != '0);
                if (r_start) begin
                    r_have_prev <= 1'b0;
                    r_pos       <= '0;
                    r_held      <= '0;
                    r_sum       <= '0;
                end
            end
            if (i_cmd.update) begin
                r_prev_close <= r_close;
                r_have_prev  <= 1'b1;
                if (r_do_upd) begin
                    r_sum <= n_sum;
                    r_pos <= n_pos;
                    if (!full_now) begin
                        r_held <= r_held + 1'b1;
                    end
                end
            end
            // a period write restarts the window
            if (i_cfg_clear) begin
                r_pos  <= '0;
                r_held <= '0;
                r_sum  <= '0;
            end
        end
    end

    trwa_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (period_eff),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_flag  <= r_win_full_q;
            r_out_value <= r_win_full_q ? quotient[PRICE_BITS-1:0] : '0;
        end
    end

    assign o_sts.win_full = win_full;
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_flag     = r_out_flag;
    assign o_out_value    = r_out_value;

    `TRWA_ASSERT_ALWAYS(a_held_le_period, i_clk, i_rst_n, r_held <= period_eff, "held count above period")
    `TRWA_ASSERT_ALWAYS(a_pos_in_window, i_clk, i_rst_n, (r_pos == '0) || (CW'(r_pos) < CW'(period_eff)), "ring position outside window")
    `TRWA_ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, r_out_valid && !r_out_flag, r_out_value == '0, "invalid result carries nonzero value")
    `TRWA_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load, out_free, "result overwritten before taken")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for true_range_window_average. Price bars go in on the
// slave stream, the block's averages come out on the master stream, and a
// scoreboard that tracks the true range window predicts every result.
// Directed bars cover the price extremes, series restarts, low above high and
// the period corner cases. Random bars (mostly well-formed series) follow,
// with bursty input, receiver stalls and period rewrites between phases.
// ----------------------------------------------------------------------------

module tb_top;

    import trwa_pkg::*;

    localparam int PX_W        = 32;
    localparam int WINDOW_MAX  = 64;
    localparam int SETTLE      = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 10;

    typedef struct packed {
        logic            series_start;
        logic [PX_W-1:0] high_px;
        logic [PX_W-1:0] low_px;
        logic [PX_W-1:0] close_px;
    } bar_t;

    typedef struct packed {
        logic            atr_valid;
        logic [PX_W-1:0] atr_value;
    } atr_result_t;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the window and holds the expected averages
    // ------------------------------------------------------------------
    class atr_scoreboard;
        logic [PERIOD_W-1:0] period_reg;
        logic [PX_W-1:0]     last_close;
        bit                  close_known;
        logic [PX_W-1:0]     ranges [WINDOW_MAX];
        int unsigned         slot;
        int unsigned         held;
        logic [37:0]         range_total;
        atr_result_t         expected_q [$];
        int unsigned         errors;

        function new();
            period_reg  = PERIOD_RESET;
            last_close  = '0;
            close_known = 0;
            errors      = 0;
            foreach (ranges[i]) ranges[i] = '0;
            restart_window();
        endfunction

        function void restart_window();
            slot        = 0;
            held        = 0;
            range_total = '0;
        endfunction

        function void write_period(logic [PERIOD_W-1:0] p);
            period_reg = p;
            restart_window();
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_bar(bar_t b);
            int unsigned   per;
            int unsigned   pos;
            logic [PX_W-1:0] tr;
            logic [PX_W-1:0] hc;
            logic [PX_W-1:0] lc;
            logic [37:0]   quot;
            atr_result_t   res;
            per = (period_reg > WINDOW_MAX) ? WINDOW_MAX : period_reg;
            if (b.series_start) begin
                close_known = 0;
                restart_window();
            end
            if (close_known && per > 0) begin
                tr = (b.high_px > b.low_px) ? b.high_px - b.low_px : '0;
                hc = (b.high_px >= last_close) ? b.high_px - last_close
                                               : last_close - b.high_px;
                lc = (b.low_px >= last_close) ? b.low_px - last_close
                                              : last_close - b.low_px;
                if (hc > tr) tr = hc;
                if (lc > tr) tr = lc;
                pos = slot;
                if (pos >= per) pos = 0;
                if (held >= per) begin
                    range_total = range_total - 38'(ranges[pos]);
                end else begin
                    held++;
                end
                range_total  = range_total + 38'(tr);
                ranges[pos]  = tr;
                pos++;
                slot = (pos >= per) ? 0 : pos;
            end
            last_close  = b.close_px;
            close_known = 1;
            if (per > 0 && held >= per) begin
                quot          = range_total / 38'(per);
                res.atr_valid = 1'b1;
                res.atr_value = quot[PX_W-1:0];
            end else begin
                res.atr_valid = 1'b0;
                res.atr_value = '0;
            end
            expected_q = {expected_q, res};
        endfunction

        function void check_result(logic valid, logic [PX_W-1:0] value);
            atr_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: valid=%b value=%0d",
                         $time, valid, value);
                return;
            end
            want = expected_q.pop_front();
            if (valid !== want.atr_valid) begin
                errors++;
                $display("%0t: atr_valid mismatch: expected %b actual %b",
                         $time, want.atr_valid, valid);
            end
            if (value !== want.atr_value) begin
                errors++;
                $display("%0t: atr_value mismatch: expected %0d actual %0d",
                         $time, want.atr_value, value);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [3*PX_W-1:0]         s_axis_tdata;   // high_price, low_price, close_price
    logic                      s_axis_tuser;   // series_start
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [PX_W-1:0]           m_axis_tdata;   // atr_value
    logic                      m_axis_tuser;   // atr_valid
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_W-1:0]     paddr;
    logic [CFG_DATA_W-1:0]     pwdata;
    logic [CFG_DATA_W-1:0]     prdata;
    logic                      pready;

    true_range_window_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    atr_scoreboard sb = new();
    bit            hold_req = 0;
    int unsigned   burst_left = 0;
    int unsigned   cycles = 0;
    longint        price_level = 64'd500000000;

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic longint clamp_px(longint v);
        if (v < 0) return 0;
        if (v > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
        return v;
    endfunction

    function automatic logic [PX_W-1:0] edge_px();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return PX_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic bar_t make_bar(int unsigned start_odds);
        bar_t        b;
        int unsigned kind;
        longint      step;
        longint      h;
        longint      l;
        b.series_start = ($urandom_range(1, start_odds) == 1);
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            // well-formed bar around a drifting price
            if ($urandom_range(0, 31) == 0) begin
                price_level = longint'($urandom);
            end else begin
                step = longint'($urandom_range(0, 40000));
                price_level = $urandom_range(0, 1) ? price_level + step
                                                   : price_level - step;
            end
            price_level = clamp_px(price_level);
            h = clamp_px(price_level + longint'($urandom_range(0, 30000)));
            l = clamp_px(price_level - longint'($urandom_range(0, 30000)));
            b.high_px  = h[PX_W-1:0];
            b.low_px   = l[PX_W-1:0];
            b.close_px = PX_W'(l + longint'($urandom_range(0, int'(h - l))));
        end else if (kind < 90) begin
            b.high_px  = edge_px();
            b.low_px   = edge_px();
            b.close_px = edge_px();
        end else begin
            b.high_px  = $urandom;
            b.low_px   = $urandom;
            b.close_px = $urandom;
        end
        return b;
    endfunction

    // Returns once the bar has been accepted,
    // with tvalid still high.
    task automatic offer_bar(input logic start, input logic [PX_W-1:0] hi,
                             input logic [PX_W-1:0] lo, input logic [PX_W-1:0] cl);
        bar_t b;
        b = '{start, hi, lo, cl};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cl, lo, hi};
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_bar(b);
    endtask

    task automatic sender_idle(input int unsigned n);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {$urandom, $urandom, $urandom};
        s_axis_tuser  <= 1'($urandom_range(0, 1));
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace_sender(input bit no_gaps);
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60)
                                              : $urandom_range(1, 12);
            if (!no_gaps && !hold_req) sender_idle(gap);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_period(input int unsigned p);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({REG_ATR_PERIOD, 2'b00});
        pwdata  <= CFG_DATA_W'(p);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_period(PERIOD_W'(p));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase_period [NUM_PHASES];
        int unsigned phase_items  [NUM_PHASES];
        int unsigned phase_odds   [NUM_PHASES];
        bar_t        b;

        phase_period = '{2, 64, 1, 0, 127, $urandom_range(4, 40), 65, 3,
                         $urandom_range(4, 40), 14};
        phase_items  = '{60, 140, 50, 25, 110, 70, 90, 60, 80, 60};
        phase_odds   = '{40, 300, 30, 10, 250, 120, 300, 40, 150, 100};

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset period: first bar, extremes, low above high, restart
        offer_bar(1'b1, '1, '0, '1);
        offer_bar(1'b0, '0, '0, '0);
        offer_bar(1'b0, '1, '1, '1);
        offer_bar(1'b0, 32'd100, 32'd5000, 32'd300);
        offer_bar(1'b1, 32'd5, 32'd5, 32'd5);

        // period one: every bar with a known previous close is averaged alone
        drain_results();
        write_period(1);
        offer_bar(1'b0, 32'd20000, 32'd10000, 32'd15000);
        offer_bar(1'b0, '1, '0, '0);
        offer_bar(1'b0, '0, '0, '1);
        offer_bar(1'b0, '1, '1, '0);
        offer_bar(1'b0, 32'd7, '1, 32'd1);
        offer_bar(1'b1, 32'd1, 32'd1, 32'd1);
        offer_bar(1'b0, 32'd3, 32'd2, 32'd2);

        // full-scale ranges push the sum past 32 bits
        drain_results();
        write_period(2);
        offer_bar(1'b0, '1, '0, '1);
        offer_bar(1'b0, '1, '0, '0);
        offer_bar(1'b0, '1, '0, '1);

        // zero period never fills the window
        drain_results();
        write_period(0);
        offer_bar(1'b0, '1, '0, '0);
        offer_bar(1'b0, 32'd9, 32'd4, 32'd6);
        offer_bar(1'b1, '0, '1, '1);

        // oversize period saturates
        drain_results();
        write_period(127);
        offer_bar(1'b0, '1, '0, '1);
        offer_bar(1'b0, 32'd12, 32'd11, 32'd10);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_period(phase_period[ph]);
            for (int n = 0; n < phase_items[ph]; n++) begin
                // long receiver hold-off while bars keep coming
                if (ph == 0 && n == 10) hold_req = 1;
                if (ph == 5 && n == 30) drain_results();
                b = make_bar(phase_odds[ph]);
                offer_bar(b.series_start, b.high_px, b.low_px, b.close_px);
                pace_sender(ph == 2);
            end
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        rx_mode_t    mode;
        int unsigned mode_left;
        mode      = RX_OPEN;
        mode_left = 0;
        m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // result transactions
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
